// File: design/tpd_pkg.sv
// Package for the trace packet deframer: phase and event codes, hex helper.
// No dependencies.
package tpd_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BODY,
        PH_CKH,
        PH_CKL,
        PH_CKL_BAD,
        PH_EMIT,
        PH_DRAIN
    } phase_t;

    localparam logic [2:0] EV_QUIT      = 3'd0;
    localparam logic [2:0] EV_SET_PC    = 3'd1;
    localparam logic [2:0] EV_SET_CLOCK = 3'd2;
    localparam logic [2:0] EV_REG_WRITE = 3'd3;
    localparam logic [2:0] EV_IO_WRITE  = 3'd4;
    localparam logic [2:0] EV_SRAM      = 3'd5;
    localparam logic [2:0] EV_CK_ERR    = 3'd6;
    localparam logic [2:0] EV_FMT_ERR   = 3'd7;

    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_END   = 8'h23;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CMD_Q = 8'h71;
    localparam logic [7:0] CMD_P = 8'h70;
    localparam logic [7:0] CMD_N = 8'h6e;
    localparam logic [7:0] CMD_R = 8'h72;
    localparam logic [7:0] CMD_I = 8'h69;
    localparam logic [7:0] CMD_S = 8'h73;
    localparam logic [31:0] IO_SPL = 32'h3d;
    localparam logic [31:0] IO_SPH = 32'h3e;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } nib_t;

    function automatic nib_t nib_of(input logic [7:0] c);
        nib_t r;
        r.ok = 1'b1;
        r.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) r.val = 4'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46) r.val = 4'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h66) r.val = 4'(c - 8'h57);
        else r.ok = 1'b0;
        return r;
    endfunction

endpackage

// File: design/trace_packet_deframer_decoder_unit.sv
// Top level of the trace packet deframer/decoder: sequencer, field decode,
// SRAM data buffer and event output register. Depends on tpd_pkg.
//
// channel  dir  handshake        payload
// byte     in   valid/ready      byte_in
// event    out  out_valid/ready  event_kind number data_value first_clock
//                                sp_valid sp_value last
//
// A byte is taken whenever valid and ready are high; after the second
// checksum byte the packet is checked in PH_EMIT, then events are emitted
// one per cycle unless out_ready stalls them (up to MAX_SRAM_BYTES for an
// sram write, read one entry a cycle from the data buffer). ready is low
// while events drain. Reset is asynchronous and clears control state; the
// data buffer is not cleared. Stalls on the output hold the sequencer.
module trace_packet_deframer_decoder_unit #(
    parameter int MAX_BODY_BYTES = 1024,
    parameter int MAX_SRAM_BYTES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        ready,
    input  logic [7:0]  byte_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  event_kind,
    output logic [31:0] number,
    output logic [7:0]  data_value,
    output logic        first_clock,
    output logic        sp_valid,
    output logic [15:0] sp_value,
    output logic        last
);
    import tpd_pkg::*;

    localparam int BCW = $clog2(MAX_BODY_BYTES + 1);
    localparam int DCW = $clog2(MAX_SRAM_BYTES + 1) + 1;
    localparam int AW  = (MAX_SRAM_BYTES > 1) ? $clog2(MAX_SRAM_BYTES) : 1;

    phase_t phase_reg, phase_next;
    logic [7:0]  sum_reg, sum_next;
    logic [BCW-1:0] bc_reg, bc_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [1:0]  fsel_reg, fsel_next;
    logic [31:0] n1_reg, n1_next, n2_reg, n2_next;
    logic [1:0]  seen_reg, seen_next;
    logic        bad_reg, bad_next;
    logic [DCW-1:0] dc_reg, dc_next;
    logic [4:0]  hn_reg, hn_next;
    logic [3:0]  ckh_reg, ckh_next;
    logic [7:0]  rxck_reg, rxck_next;
    logic        hexbad_reg, hexbad_next;
    logic        clk_seen_reg, clk_seen_next;
    logic [15:0] sp_reg, sp_next;
    logic [DCW-1:0] di_reg, di_next;
    logic [7:0]  mem [MAX_SRAM_BYTES];
    logic        wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]  wr_data, rd_data;

    logic        ov_reg, ov_next;
    logic [2:0]  ok_reg, ok_next;
    logic [31:0] on_reg, on_next;
    logic [7:0]  od_reg, od_next;
    logic        ofc_reg, ofc_next, ospv_reg, ospv_next, ol_reg, ol_next;
    logic [15:0] osp_reg, osp_next;

    nib_t nb;
    logic acc, emit_free;
    logic [7:0] rx;
    logic [DCW-1:0] ncount;

    assign nb = nib_of(byte_in);
    assign emit_free = !ov_reg || out_ready;
    assign ready = (phase_reg != PH_EMIT) && (phase_reg != PH_DRAIN) && emit_free;
    assign acc = valid && ready;
    assign rx = {ckh_reg, nb.ok ? nb.val : 4'd0};
    assign ncount = (dc_reg < DCW'(MAX_SRAM_BYTES)) ? dc_reg : DCW'(MAX_SRAM_BYTES);
    assign rd_addr = di_next[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE; sum_reg <= '0; bc_reg <= '0; cmd_reg <= '0;
            fsel_reg <= '0; n1_reg <= '0; n2_reg <= '0; seen_reg <= '0;
            bad_reg <= 1'b0; dc_reg <= '0; hn_reg <= '0; ckh_reg <= '0;
            rxck_reg <= '0;
            hexbad_reg <= 1'b0; clk_seen_reg <= 1'b0; sp_reg <= '0; di_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next; sum_reg <= sum_next; bc_reg <= bc_next;
            cmd_reg <= cmd_next; fsel_reg <= fsel_next; n1_reg <= n1_next;
            n2_reg <= n2_next; seen_reg <= seen_next; bad_reg <= bad_next;
            dc_reg <= dc_next; hn_reg <= hn_next; ckh_reg <= ckh_next;
            rxck_reg <= rxck_next;
            hexbad_reg <= hexbad_next; clk_seen_reg <= clk_seen_next;
            sp_reg <= sp_next; di_reg <= di_next; ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg <= ok_next; on_reg <= on_next; od_reg <= od_next;
        ofc_reg <= ofc_next; ospv_reg <= ospv_next; osp_reg <= osp_next;
        ol_reg <= ol_next;
    end

    always_comb
    begin
        logic [7:0] sep;
        logic [15:0] spn;
        phase_next = phase_reg; sum_next = sum_reg; bc_next = bc_reg;
        cmd_next = cmd_reg; fsel_next = fsel_reg; n1_next = n1_reg;
        n2_next = n2_reg; seen_next = seen_reg; bad_next = bad_reg;
        dc_next = dc_reg; hn_next = hn_reg; ckh_next = ckh_reg;
        rxck_next = rxck_reg;
        hexbad_next = hexbad_reg; clk_seen_next = clk_seen_reg; sp_next = sp_reg;
        di_next = di_reg;
        ov_next = ov_reg && !out_ready;
        ok_next = ok_reg; on_next = on_reg; od_next = od_reg; ofc_next = ofc_reg;
        ospv_next = ospv_reg; osp_next = osp_reg; ol_next = ol_reg;
        wr_en = 1'b0;
        wr_addr = dc_reg[AW-1:0];
        wr_data = {hn_reg[3:0], nb.val};
        sep = 8'd0;
        spn = sp_reg;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (acc && byte_in == CH_START)
                begin
                    phase_next = PH_BODY; sum_next = '0; bc_next = '0; cmd_next = '0;
                    fsel_next = '0; n1_next = '0; n2_next = '0; seen_next = '0;
                    bad_next = 1'b0; dc_next = '0; hn_next = '0; ckh_next = '0;
                end
            end
            PH_BODY:
            begin
                if (acc)
                begin
                    if (byte_in == CH_END) phase_next = PH_CKH;
                    else if (bc_reg >= BCW'(MAX_BODY_BYTES))
                    begin
                        bad_next = 1'b1; phase_next = PH_CKH;
                    end
                    else
                    begin
                        sum_next = sum_reg + byte_in;
                        bc_next = bc_reg + 1'b1;
                        if (bc_reg == '0) cmd_next = byte_in;
                        else if ((cmd_reg == CMD_P || cmd_reg == CMD_N || cmd_reg == CMD_R
                                  || cmd_reg == CMD_I || cmd_reg == CMD_S)
                                 && fsel_reg != 2'd3)
                        begin
                            if (fsel_reg < 2'd2)
                            begin
                                if (fsel_reg == 2'd0)
                                    sep = (cmd_reg == CMD_S) ? CH_COMMA :
                                          (cmd_reg == CMD_R || cmd_reg == CMD_I)
                                          ? CH_COLON : 8'd0;
                                else
                                    sep = (cmd_reg == CMD_S) ? CH_COLON : 8'd0;
                                if (nb.ok)
                                begin
                                    if (fsel_reg == 2'd0) n1_next = {n1_reg[27:0], nb.val};
                                    else n2_next = {n2_reg[27:0], nb.val};
                                    seen_next[fsel_reg[0]] = 1'b1;
                                end
                                else if (!seen_reg[fsel_reg[0]])
                                begin
                                    bad_next = 1'b1; fsel_next = 2'd3;
                                end
                                else if (sep == 8'd0) fsel_next = 2'd3;
                                else if (byte_in != sep)
                                begin
                                    bad_next = 1'b1; fsel_next = 2'd3;
                                end
                                else if (fsel_reg == 2'd0) fsel_next = 2'd1;
                                else if (n2_reg > 32'(MAX_SRAM_BYTES))
                                begin
                                    bad_next = 1'b1; fsel_next = 2'd3;
                                end
                                else fsel_next = (n2_reg == '0) ? 2'd3 : 2'd2;
                            end
                            else if (!nb.ok)
                            begin
                                bad_next = 1'b1; fsel_next = 2'd3;
                            end
                            else if (hn_reg[4])
                            begin
                                // length is bounded, so data_count stays in range
                                wr_en = 1'b1;
                                dc_next = dc_reg + 1'b1;
                                hn_next = '0;
                                if (32'(dc_next) >= n2_reg) fsel_next = 2'd3;
                            end
                            else hn_next = {1'b1, nb.val};
                        end
                    end
                end
            end
            PH_CKH:
            begin
                if (acc)
                begin
                    ckh_next = nb.val;
                    phase_next = nb.ok ? PH_CKL : PH_CKL_BAD;
                end
            end
            PH_CKL, PH_CKL_BAD:
            begin
                if (acc)
                begin
                    hexbad_next = (phase_reg == PH_CKL_BAD) || !nb.ok;
                    rxck_next = rx;
                    phase_next = PH_EMIT;
                end
            end
            PH_EMIT:
            begin
                // output register is free here (ready required it at entry)
                phase_next = PH_IDLE;
                ok_next = EV_FMT_ERR; on_next = '0; od_next = '0; ofc_next = 1'b0;
                ospv_next = 1'b0; osp_next = '0; ol_next = 1'b1;
                ov_next = 1'b1;
                if (hexbad_reg) ok_next = EV_FMT_ERR;
                else if (rxck_reg != sum_reg) ok_next = EV_CK_ERR;
                else if (bad_reg) ok_next = EV_FMT_ERR;
                else if (bc_reg == '0) ov_next = 1'b0;
                else
                begin
                    unique case (cmd_reg)
                        CMD_Q: ok_next = EV_QUIT;
                        CMD_P, CMD_N:
                        begin
                            if (seen_reg[0])
                            begin
                                on_next = n1_reg;
                                if (cmd_reg == CMD_P) ok_next = EV_SET_PC;
                                else
                                begin
                                    ok_next = EV_SET_CLOCK;
                                    ofc_next = !clk_seen_reg;
                                    clk_seen_next = 1'b1;
                                end
                            end
                        end
                        CMD_R, CMD_I:
                        begin
                            if (seen_reg == 2'b11)
                            begin
                                on_next = n1_reg; od_next = n2_reg[7:0];
                                ok_next = (cmd_reg == CMD_R) ? EV_REG_WRITE : EV_IO_WRITE;
                                if (cmd_reg == CMD_I && (n1_reg == IO_SPL || n1_reg == IO_SPH))
                                begin
                                    if (n1_reg == IO_SPL) spn = {sp_reg[15:8], n2_reg[7:0]};
                                    else spn = {n2_reg[7:0], sp_reg[7:0]};
                                    sp_next = spn; ospv_next = 1'b1; osp_next = spn;
                                end
                            end
                        end
                        CMD_S:
                        begin
                            if (fsel_reg == 2'd3)
                            begin
                                ov_next = 1'b0;
                                di_next = '0;
                                if (ncount != '0) phase_next = PH_DRAIN;
                            end
                        end
                        default: ov_next = 1'b0;
                    endcase
                end
            end
            PH_DRAIN:
            begin
                if (emit_free)
                begin
                    ok_next = EV_SRAM; on_next = n1_reg + 32'(di_reg);
                    od_next = rd_data; ofc_next = 1'b0; ospv_next = 1'b0;
                    osp_next = '0; ov_next = 1'b1;
                    ol_next = (di_reg + 1'b1 == ncount);
                    di_next = di_reg + 1'b1;
                    if (ol_next) phase_next = PH_IDLE;
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    assign out_valid = ov_reg;
    assign event_kind = ok_reg;
    assign number = on_reg;
    assign data_value = od_reg;
    assign first_clock = ofc_reg;
    assign sp_valid = ospv_reg;
    assign sp_value = osp_reg;
    assign last = ol_reg;
endmodule

// File: design/trace_packet_deframer_decoder_unit_checker.sv
// Port-level checker for the trace packet deframer, with its bind.
// Depends on tpd_pkg for event codes.
module tpd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        valid,
    input logic        ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  event_kind,
    input logic [31:0] number,
    input logic        first_clock,
    input logic        sp_valid,
    input logic        last
);
    import tpd_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(number))
        else $error("stalled event changed");

    a_fc_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && first_clock |-> event_kind == EV_SET_CLOCK)
        else $error("first_clock on wrong event");

    a_sp_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sp_valid |-> event_kind == EV_IO_WRITE)
        else $error("sp_valid on wrong event");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind == EV_CK_ERR || event_kind == EV_FMT_ERR) |-> last)
        else $error("error event not last");
endmodule

bind trace_packet_deframer_decoder_unit tpd_checker u_chk (.*);
